// ----- rtl/range_op_array_engine_core_macros.svh -----
// Assertion macros shared by the range operation engine RTL.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef RANGE_OP_ARRAY_ENGINE_CORE_MACROS_SVH
`define RANGE_OP_ARRAY_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ROAE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ROAE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/roae_pkg.sv -----
// Package for the range operation engine: opcodes, command and beat types,
// modular helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package roae_pkg;

    localparam logic [29:0] MODULUS = 30'd1000000007;
    localparam int          QDEPTH  = 2;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_SUM     = 3'd1,
        OP_ASSIGN  = 3'd2,
        OP_ADD     = 3'd3,
        OP_COPY    = 3'd4,
        OP_SWAP    = 3'd5,
        OP_REVERSE = 3'd6,
        OP_READ    = 3'd7
    } opcode_t;

    // What a beat does once its read data is back
    typedef enum logic [2:0] {
        ACT_SET,
        ACT_SUM,
        ACT_ADD,
        ACT_CAPA,
        ACT_CAPB,
        ACT_WRA,
        ACT_WRB,
        ACT_READ
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_GAP
    } state_t;

    // Classified request handed from front to back
    typedef struct packed {
        opcode_t     op;
        logic [10:0] lo1;
        logic [10:0] lo2;
        logic [11:0] len;
        logic [29:0] val;
    } cmd_t;

    // (a + b) mod P for a, b below P
    function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS})
            return 30'(s - {1'b0, MODULUS});
        return s[29:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/roae_front.sv -----
// Front end: takes requests, reduces the operand, computes range length,
// and queues classified commands. Depends on roae_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "range_op_array_engine_core_macros.svh"
module roae_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        operation,
    input  wire logic [10:0]       first_low,
    input  wire logic [10:0]       first_high,
    input  wire logic [10:0]       second_low,
    input  wire logic [29:0]       operand_value,
    output logic                   cmd_valid,
    output roae_pkg::cmd_t         cmd_out,
    input  wire logic              cmd_pop
);
    import roae_pkg::*;

    cmd_t        q_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    cmd_t        cmd_new;

    // Classify the incoming request
    always_comb
    begin
        cmd_new.op  = opcode_t'(operation);
        cmd_new.lo1 = first_low;
        cmd_new.lo2 = second_low;
        cmd_new.len = (first_high >= first_low)
                    ? ({1'b0, first_high} - {1'b0, first_low} + 12'd1) : 12'd0;
        cmd_new.val = (operand_value >= MODULUS) ? (operand_value - MODULUS)
                                                 : operand_value;
    end

    assign busy      = (cnt_reg == 2'(QDEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out   = q_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cmd_new;
    end

    `ROAE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= 2'(QDEPTH), "queue overfilled")
    `ROAE_ASSERT_IMP(a_pop_nonempty, cmd_pop, cnt_reg != 2'd0, "pop from empty queue")
    `ROAE_ASSERT_IMP(a_ptr_match, (cnt_reg == 2'd0) || (cnt_reg == 2'(QDEPTH)),
        wr_ptr_reg == rd_ptr_reg, "queue pointers out of step")

endmodule
`default_nettype wire

// ----- rtl/roae_back.sv -----
// Back end: sequences memory passes for each command over the element store
// and two scratch buffers. Depends on roae_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "range_op_array_engine_core_macros.svh"
module roae_back
#(
    parameter int ARRAY_LENGTH = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire roae_pkg::cmd_t    cmd_in,
    output logic                   cmd_pop,
    output logic                   result_strobe,
    output logic [29:0]            result_value
);
    import roae_pkg::*;

    localparam int          AW      = $clog2(ARRAY_LENGTH);
    localparam logic [31:0] LEN_TOP = 32'(ARRAY_LENGTH);

    typedef struct packed {
        logic          valid;
        act_t          act;
        logic          pos_ok;
        logic [AW-1:0] addr;
        logic [10:0]   bidx;
        logic          last;
    } beat_t;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [1:0]  pass_reg, pass_next;
    logic [11:0] idx_reg, idx_next;
    logic [29:0] acc_reg, acc_next;
    beat_t       s1_reg, s1_next;
    logic        strobe_reg, strobe_next;
    logic [29:0] value_reg, value_next;

    logic [29:0] mem [ARRAY_LENGTH];
    logic [29:0] buf_a [2048];
    logic [29:0] buf_b [2048];
    logic [29:0] mem_rd_reg, bufa_rd_reg, bufb_rd_reg;

    act_t        p_act;
    logic [10:0] p_base;
    logic        p_rev, p_last;
    logic [11:0] p_count;
    logic [11:0] pos;
    logic [31:0] pos_m1;
    logic [11:0] ridx;
    logic [29:0] rd_val;
    logic        mem_we;
    logic [29:0] mem_wd;

    // Pass table per opcode
    always_comb
    begin
        p_act  = ACT_SET;
        p_base = cmd_reg.lo1;
        p_rev  = 1'b0;
        p_last = 1'b1;
        case (cmd_reg.op)
            OP_LOAD:   p_act = ACT_SET;
            OP_SUM:    p_act = ACT_SUM;
            OP_ASSIGN: p_act = ACT_SET;
            OP_ADD:    p_act = ACT_ADD;
            OP_READ:   p_act = ACT_READ;
            OP_COPY:
            begin
                p_last = (pass_reg == 2'd1);
                if (pass_reg == 2'd0)
                    p_act = ACT_CAPA;
                else
                begin
                    p_act  = ACT_WRA;
                    p_base = cmd_reg.lo2;
                end
            end
            OP_SWAP:
            begin
                p_last = (pass_reg == 2'd3);
                case (pass_reg)
                    2'd0: p_act = ACT_CAPA;
                    2'd1:
                    begin
                        p_act  = ACT_CAPB;
                        p_base = cmd_reg.lo2;
                    end
                    2'd2: p_act = ACT_WRB;
                    default:
                    begin
                        p_act  = ACT_WRA;
                        p_base = cmd_reg.lo2;
                    end
                endcase
            end
            OP_REVERSE:
            begin
                p_last = (pass_reg == 2'd1);
                p_act  = (pass_reg == 2'd0) ? ACT_CAPA : ACT_WRA;
                p_rev  = (pass_reg == 2'd1);
            end
            default: p_act = ACT_SET;
        endcase
        p_count = ((cmd_reg.op == OP_LOAD) || (cmd_reg.op == OP_READ)) ? 12'd1
                                                                       : cmd_reg.len;
    end

    // Beat address for the current index
    always_comb
    begin
        pos    = {1'b0, p_base} + idx_reg;
        pos_m1 = 32'(pos) - 32'd1;
        ridx   = cmd_reg.len - 12'd1 - idx_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pass_next   = pass_reg;
        idx_next    = idx_reg;
        cmd_pop     = 1'b0;
        s1_next     = '0;
        s1_next.act = p_act;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_in;
                    pass_next  = 2'd0;
                    idx_next   = 12'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (idx_reg < p_count)
                begin
                    s1_next.valid  = 1'b1;
                    s1_next.pos_ok = (pos != 12'd0) && (32'(pos) <= LEN_TOP);
                    s1_next.addr   = pos_m1[AW-1:0];
                    s1_next.bidx   = p_rev ? ridx[10:0] : idx_reg[10:0];
                    s1_next.last   = (idx_reg == p_count - 12'd1);
                    idx_next       = idx_reg + 12'd1;
                end
                else
                    state_next = ST_GAP;
            end
            ST_GAP:
            begin
                idx_next = 12'd0;
                if (p_last)
                    state_next = ST_IDLE;
                else
                begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Second stage: act on read data
    always_comb
    begin
        rd_val      = s1_reg.pos_ok ? mem_rd_reg : 30'd0;
        mem_we      = 1'b0;
        mem_wd      = cmd_reg.val;
        acc_next    = (state_reg == ST_IDLE) ? 30'd0 : acc_reg;
        strobe_next = 1'b0;
        value_next  = value_reg;
        if (s1_reg.valid)
        begin
            case (s1_reg.act)
                ACT_SET:
                begin
                    mem_we = s1_reg.pos_ok;
                    mem_wd = cmd_reg.val;
                end
                ACT_ADD:
                begin
                    mem_we = s1_reg.pos_ok;
                    mem_wd = add_mod(mem_rd_reg, cmd_reg.val);
                end
                ACT_WRA:
                begin
                    mem_we = s1_reg.pos_ok;
                    mem_wd = bufa_rd_reg;
                end
                ACT_WRB:
                begin
                    mem_we = s1_reg.pos_ok;
                    mem_wd = bufb_rd_reg;
                end
                ACT_SUM:
                begin
                    acc_next = add_mod(acc_reg, rd_val);
                    if (s1_reg.last)
                    begin
                        strobe_next = 1'b1;
                        value_next  = add_mod(acc_reg, rd_val);
                    end
                end
                ACT_READ:
                begin
                    strobe_next = 1'b1;
                    value_next  = rd_val;
                end
                default: mem_we = 1'b0;
            endcase
        end
        // Empty range sum answers zero
        if ((state_reg == ST_RUN) && (p_count == 12'd0) && (p_act == ACT_SUM))
        begin
            strobe_next = 1'b1;
            value_next  = 30'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pass_reg   <= 2'd0;
            idx_reg    <= 12'd0;
            s1_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            idx_reg    <= idx_next;
            s1_reg     <= s1_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
    end

    // Element store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[s1_reg.addr] <= mem_wd;
        mem_rd_reg <= mem[s1_next.addr];
    end

    // Scratch buffers
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid && (s1_reg.act == ACT_CAPA))
            buf_a[s1_reg.bidx] <= rd_val;
        bufa_rd_reg <= buf_a[s1_next.bidx];
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.valid && (s1_reg.act == ACT_CAPB))
            buf_b[s1_reg.bidx] <= rd_val;
        bufb_rd_reg <= buf_b[s1_next.bidx];
    end

    assign result_strobe = strobe_reg;
    assign result_value  = value_reg;

    `ROAE_ASSERT_IMP(a_beat_from_run, s1_reg.valid, $past(state_reg == ST_RUN),
        "beat issued outside run")
    `ROAE_ASSERT_NXT(a_gap_drains, state_reg == ST_GAP, !s1_reg.valid,
        "beat issued during gap")
    `ROAE_ASSERT_IMP(a_strobe_src, strobe_reg,
        $past(s1_reg.valid) || $past(state_reg == ST_RUN), "result without source")

endmodule
`default_nettype wire

// ----- rtl/range_op_array_engine_core.sv -----
// Range operation engine, top level: a front queue of requests and a back
// sequencer over the element memory. Depends on roae_pkg, roae_front, roae_back.
//
// Usage: drive operation and the range/operand fields with start high; the
// request is taken on a clock edge where busy is low. Up to two requests wait
// in the front queue while the back end works. Sum and read give one result:
// result_strobe is high for one cycle with result_value; it cannot be held off.
// Each request runs as one or more passes over its range, one element per
// cycle within a pass: load and read touch one element; sum, assign and
// add make one pass; copy and reverse make two passes; swap makes four
// (len up to 2048).
// A sum result is registered from the read data of its last element beat,
// or is zero for an empty range; a read result from its single beat.
// Reset clears the queue and sequencer; memory contents are undefined until
// loaded. No clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
module range_op_array_engine_core
#(
    parameter int ARRAY_LENGTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  operation,
    input  wire logic [10:0] first_low,
    input  wire logic [10:0] first_high,
    input  wire logic [10:0] second_low,
    input  wire logic [10:0] second_high,
    input  wire logic [29:0] operand_value,
    output logic             result_strobe,
    output logic [29:0]      result_value
);
    import roae_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // second_high is implied by the first range length
    roae_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .first_low     (first_low),
        .first_high    (first_high),
        .second_low    (second_low),
        .operand_value (operand_value),
        .cmd_valid     (cmd_valid),
        .cmd_out       (cmd),
        .cmd_pop       (cmd_pop)
    );

    roae_back #(.ARRAY_LENGTH(ARRAY_LENGTH)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_in        (cmd),
        .cmd_pop       (cmd_pop),
        .result_strobe (result_strobe),
        .result_value  (result_value)
    );

endmodule
`default_nettype wire
